@@ sv/gif_metadata_stream_extractor_macros.svh @@
// Assertion macros shared by the GIF metadata stream extractor.
`ifndef GIF_METADATA_STREAM_EXTRACTOR_MACROS_SVH
`define GIF_METADATA_STREAM_EXTRACTOR_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define GMSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define GMSE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define GMSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define GMSE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ sv/gmse_pkg.sv @@
// Types, constants and lookup functions of the GIF metadata stream extractor.
package gmse_pkg;

    // Payload length counter width and XMP trailer padding.
    localparam int LENGTH_BITS   = 24;
    localparam int PAYLOAD_LEN_W = 24;
    localparam int XMP_PADDING   = 257;
    localparam int SKIP_W        = 10;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Status codes
    localparam logic [1:0] ST_PARSING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_SHORT   = 2'd3;

    // Payload kinds
    localparam logic KIND_XMP = 1'b0;
    localparam logic KIND_ICC = 1'b1;

    // Segment and block bytes
    localparam logic [7:0] BYTE_EXT     = 8'h21;
    localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
    localparam logic [7:0] BYTE_TRAILER = 8'h3B;
    localparam logic [7:0] BYTE_APP_EXT = 8'hFF;
    localparam logic [7:0] BYTE_APP_LEN = 8'h0B;

    // Signature candidates: bit 0 first version/identifier, bit 1 second
    localparam logic [1:0] CAND_BOTH = 2'b11;

    typedef enum logic [4:0] {
        PH_SIG,
        PH_LSD,
        PH_GCT,
        PH_SEG,
        PH_EXT_LABEL,
        PH_APP_SIZE,
        PH_APP_ID,
        PH_SUB_SIZE,
        PH_SUB_DATA,
        PH_IMG,
        PH_LCT,
        PH_LZW,
        PH_META_SIZE,
        PH_META_DATA,
        PH_HALT
    } t_phase;

    // One classified byte handed from the parser to the output side
    typedef struct packed {
        logic       emit;
        logic       fin;
        logic       clr;
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
    } t_cmd;

    // "GIF"
    function automatic logic [7:0] sig_head_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h47;
            2'd1:    r = 8'h49;
            2'd2:    r = 8'h46;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "87a"
    function automatic logic [7:0] ver87_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h38;
            2'd1:    r = 8'h37;
            2'd2:    r = 8'h61;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "89a"
    function automatic logic [7:0] ver89_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h38;
            2'd1:    r = 8'h39;
            2'd2:    r = 8'h61;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "XMP DataXMP"
    function automatic logic [7:0] xmp_id_byte(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h58;
            4'd1:    r = 8'h4D;
            4'd2:    r = 8'h50;
            4'd3:    r = 8'h20;
            4'd4:    r = 8'h44;
            4'd5:    r = 8'h61;
            4'd6:    r = 8'h74;
            4'd7:    r = 8'h61;
            4'd8:    r = 8'h58;
            4'd9:    r = 8'h4D;
            4'd10:   r = 8'h50;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "ICCRGBG1012"
    function automatic logic [7:0] icc_id_byte(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h49;
            4'd1:    r = 8'h43;
            4'd2:    r = 8'h43;
            4'd3:    r = 8'h52;
            4'd4:    r = 8'h47;
            4'd5:    r = 8'h42;
            4'd6:    r = 8'h47;
            4'd7:    r = 8'h31;
            4'd8:    r = 8'h30;
            4'd9:    r = 8'h31;
            4'd10:   r = 8'h32;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Color table size: 3 * (2 << n) bytes when bit 7 of the flags is set
    function automatic logic [SKIP_W-1:0] table_bytes(input logic [7:0] flags);
        logic [SKIP_W-1:0] r;
        if (flags[7]) begin
            r = SKIP_W'(10'd6 << flags[2:0]);
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

@@ sv/gif_metadata_stream_extractor.sv @@
// Top level of the GIF metadata stream extractor.
//
// Input stream: one GIF file byte per transfer in s_axis_tdata[7:0];
// s_axis_tlast marks the final byte of a buffer, after which the parser
// returns to the signature check with all taken flags cleared.
// Output stream: exactly one result transfer per input byte, in order.
//   tuser[0] payload byte valid, tuser[1] kind (0 XMP, 1 ICC),
//   tlast    terminator of a kept payload block,
//   tdata    payload byte, final length (nonzero only with tlast), status.
// Throughput: one byte per cycle while the receiver keeps tready high. The
// parser updates its state in the cycle a byte is accepted; a two-entry
// queue and the output register follow, in that order.
// Reset (synchronous, active low) puts the parser at the signature and
// empties the queue and the output register.
// When the receiver stalls the output register holds, the queue fills,
// and s_axis_tready drops once both queue entries are occupied.
`include "gif_metadata_stream_extractor_macros.svh"

module gif_metadata_stream_extractor
    import gmse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tlast,   // buffer_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] payload_byte, [31:8] payload_length,
                                          // [33:32] status, [39:34] zero
    output logic [1:0]  o_m_axis_tuser,   // [0] payload_valid, [1] payload_kind
    output logic        o_m_axis_tlast    // payload_end
);

    t_cmd                     w_push_cmd;
    t_cmd                     w_q_cmd;
    logic                     w_push;
    logic                     w_full;
    logic                     w_q_valid;
    logic                     w_pop;
    logic                     w_pvalid;
    logic                     w_kind;
    logic [7:0]               w_data;
    logic                     w_end;
    logic [PAYLOAD_LEN_W-1:0] w_length;
    logic [1:0]               w_status;

    // Parser
    gmse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // Command queue
    gmse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    // Output stage
    gmse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_cmd    (w_q_cmd),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_pvalid (w_pvalid),
        .o_kind   (w_kind),
        .o_data   (w_data),
        .o_end    (w_end),
        .o_length (w_length),
        .o_status (w_status)
    );

    assign o_m_axis_tdata = {6'd0, w_status, w_length, w_data};
    assign o_m_axis_tuser = {w_kind, w_pvalid};
    assign o_m_axis_tlast = w_end;

    // Checks
    `GMSE_ASSERT_NEVER(a_byte_and_end, i_clk, i_rst_n, o_m_axis_tvalid && w_pvalid && w_end, "payload byte and terminator in one transfer")
    `GMSE_ASSERT_NEVER(a_len_only_at_end, i_clk, i_rst_n, o_m_axis_tvalid && !w_end && (w_length != '0), "length outside a terminator")
    `GMSE_ASSERT(a_push_reaches_back, i_clk, i_rst_n, w_push |=> w_q_valid, "queued command not visible to output stage")

endmodule

@@ sv/gmse_front.sv @@
// Parser front end: walks the GIF structure and classifies every byte.
module gmse_front
    import gmse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase            r_phase, n_phase, w_step_phase;
    logic [SKIP_W-1:0] r_skip, n_skip;
    logic [3:0]        r_idx, n_idx;
    logic [1:0]        r_cand, n_cand;
    logic              r_xmp_taken, n_xmp_taken;
    logic              r_icc_taken, n_icc_taken;
    logic              r_kind, n_kind;
    logic [1:0]        r_final, n_final, w_step_final;
    logic              r_any, n_any;
    logic              w_fire;
    logic [1:0]        w_vk;
    logic [1:0]        w_live_ver;
    logic [1:0]        w_live_id;

    assign o_ready = !i_full;
    assign w_fire  = i_valid && !i_full;
    assign o_push  = w_fire;

    // Version byte index and candidate match vectors
    assign w_vk       = 2'(r_idx - 4'd3);
    assign w_live_ver = r_cand & {i_byte == ver89_byte(w_vk), i_byte == ver87_byte(w_vk)};
    assign w_live_id  = r_cand & {i_byte == icc_id_byte(r_idx), i_byte == xmp_id_byte(r_idx)};

    // Next state
    always_comb begin
        n_phase     = r_phase;
        n_skip      = r_skip;
        n_idx       = r_idx;
        n_cand      = r_cand;
        n_xmp_taken = r_xmp_taken;
        n_icc_taken = r_icc_taken;
        n_kind      = r_kind;
        n_final     = r_final;
        n_any       = r_any;
        if (w_fire) begin
            case (r_phase)
                PH_SIG: begin
                    if (r_idx < 4'd3) begin
                        if (i_byte != sig_head_byte(r_idx[1:0])) begin
                            n_final = ST_ERROR;
                            n_phase = PH_HALT;
                        end else begin
                            n_idx = r_idx + 4'd1;
                        end
                    end else begin
                        n_cand = w_live_ver;
                        if (w_live_ver == 2'b00) begin
                            n_final = ST_ERROR;
                            n_phase = PH_HALT;
                        end else if (w_vk == 2'd2) begin
                            n_idx   = '0;
                            n_phase = PH_LSD;
                        end else begin
                            n_idx = r_idx + 4'd1;
                        end
                    end
                end
                PH_LSD: begin
                    if (r_idx == 4'd4) begin
                        n_skip = table_bytes(i_byte);
                    end
                    if (r_idx >= 4'd6) begin
                        n_idx   = '0;
                        n_phase = (r_skip != '0) ? PH_GCT : PH_SEG;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_GCT, PH_LCT, PH_SUB_DATA: begin
                    if (r_skip <= SKIP_W'(1)) begin
                        n_skip  = '0;
                        n_phase = (r_phase == PH_GCT) ? PH_SEG :
                                  (r_phase == PH_LCT) ? PH_LZW : PH_SUB_SIZE;
                    end else begin
                        n_skip = r_skip - SKIP_W'(1);
                    end
                end
                PH_SEG: begin
                    if (i_byte == BYTE_TRAILER) begin
                        n_final = ST_DONE;
                        n_phase = PH_HALT;
                    end else if (i_byte == BYTE_EXT) begin
                        n_phase = PH_EXT_LABEL;
                    end else if (i_byte == BYTE_IMAGE) begin
                        n_idx   = '0;
                        n_phase = PH_IMG;
                    end else begin
                        n_final = ST_ERROR;
                        n_phase = PH_HALT;
                    end
                end
                PH_EXT_LABEL: begin
                    n_phase = (i_byte == BYTE_APP_EXT) ? PH_APP_SIZE : PH_SUB_SIZE;
                end
                PH_APP_SIZE: begin
                    if (i_byte == BYTE_APP_LEN) begin
                        n_idx   = '0;
                        n_cand  = CAND_BOTH;
                        n_phase = PH_APP_ID;
                    end else if (i_byte == 8'd0) begin
                        n_phase = PH_SEG;
                    end else begin
                        n_skip  = SKIP_W'(i_byte);
                        n_phase = PH_SUB_DATA;
                    end
                end
                PH_APP_ID: begin
                    n_cand = w_live_id;
                    if (r_idx == 4'd10) begin
                        n_idx = '0;
                        n_any = 1'b0;
                        if (w_live_id[0] && !r_xmp_taken) begin
                            n_kind  = KIND_XMP;
                            n_phase = PH_META_SIZE;
                        end else if (w_live_id[1] && !r_icc_taken) begin
                            n_kind  = KIND_ICC;
                            n_phase = PH_META_SIZE;
                        end else begin
                            n_phase = PH_SUB_SIZE;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_SUB_SIZE: begin
                    if (i_byte == 8'd0) begin
                        n_phase = PH_SEG;
                    end else begin
                        n_skip  = SKIP_W'(i_byte);
                        n_phase = PH_SUB_DATA;
                    end
                end
                PH_IMG: begin
                    if (r_idx >= 4'd8) begin
                        n_idx   = '0;
                        n_skip  = table_bytes(i_byte);
                        n_phase = (table_bytes(i_byte) != '0) ? PH_LCT : PH_LZW;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                PH_LZW: begin
                    n_phase = PH_SUB_SIZE;
                end
                PH_META_SIZE: begin
                    if (i_byte == 8'd0) begin
                        if (r_any) begin
                            if (r_kind == KIND_XMP) begin
                                n_xmp_taken = 1'b1;
                            end else begin
                                n_icc_taken = 1'b1;
                            end
                        end
                        n_phase = PH_SEG;
                    end else begin
                        n_skip = SKIP_W'(i_byte);
                        if (r_kind == KIND_XMP) begin
                            n_any = 1'b1;
                        end
                        n_phase = PH_META_DATA;
                    end
                end
                PH_META_DATA: begin
                    n_any = 1'b1;
                    if (r_skip <= SKIP_W'(1)) begin
                        n_skip  = '0;
                        n_phase = PH_META_SIZE;
                    end else begin
                        n_skip = r_skip - SKIP_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
        end
        w_step_phase = n_phase;
        w_step_final = n_final;
        // End of buffer returns the parser to the header
        if (w_fire && i_last) begin
            n_phase     = PH_SIG;
            n_skip      = '0;
            n_idx       = '0;
            n_cand      = CAND_BOTH;
            n_xmp_taken = 1'b0;
            n_icc_taken = 1'b0;
            n_kind      = KIND_XMP;
            n_final     = ST_PARSING;
            n_any       = 1'b0;
        end
    end

    // Command for the output side
    always_comb begin
        o_cmd = '0;
        case (r_phase)
            PH_APP_ID: begin
                o_cmd.clr = (r_idx == 4'd10);
            end
            PH_META_SIZE: begin
                o_cmd.kind = r_kind;
                if (i_byte == 8'd0) begin
                    o_cmd.fin = 1'b1;
                end else if (r_kind == KIND_XMP) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.data = i_byte;
                end else begin
                    o_cmd.kind = 1'b0;
                end
            end
            PH_META_DATA: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = r_kind;
                o_cmd.data = i_byte;
            end
            default: begin
                o_cmd.clr = 1'b0;
            end
        endcase
        o_cmd.status = (w_step_phase == PH_HALT) ? w_step_final : ST_PARSING;
        if (i_last && (w_step_phase != PH_HALT)) begin
            o_cmd.status = (w_step_phase == PH_SIG) ? ST_ERROR : ST_SHORT;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_skip      <= '0;
            r_idx       <= '0;
            r_cand      <= CAND_BOTH;
            r_xmp_taken <= 1'b0;
            r_icc_taken <= 1'b0;
            r_kind      <= KIND_XMP;
            r_final     <= ST_PARSING;
            r_any       <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_skip      <= n_skip;
            r_idx       <= n_idx;
            r_cand      <= n_cand;
            r_xmp_taken <= n_xmp_taken;
            r_icc_taken <= n_icc_taken;
            r_kind      <= n_kind;
            r_final     <= n_final;
            r_any       <= n_any;
        end
    end

endmodule

@@ sv/gmse_queue.sv @@
// Short command queue between the parser and the output stage.
module gmse_queue
    import gmse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_entry[r_rptr];
    assign w_pop   = i_pop && o_valid;

    // Pointer and fill updates
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
        end
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ sv/gmse_back.sv @@
// Output side: counts payload bytes, forms the length and drives the result register.
module gmse_back
    import gmse_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_cmd                     i_cmd,
    output logic                     o_pop,
    output logic                     o_tvalid,
    input  logic                     i_tready,
    output logic                     o_pvalid,
    output logic                     o_kind,
    output logic [7:0]               o_data,
    output logic                     o_end,
    output logic [PAYLOAD_LEN_W-1:0] o_length,
    output logic [1:0]               o_status
);

    localparam logic [LENGTH_BITS-1:0] CountMax = '1;
    localparam logic [LENGTH_BITS-1:0] Padding  = LENGTH_BITS'(XMP_PADDING);

    logic [LENGTH_BITS-1:0]   r_count, n_count;
    logic [LENGTH_BITS-1:0]   w_len;
    logic                     r_tvalid;
    logic                     r_pvalid, r_kind, r_end;
    logic [7:0]               r_data;
    logic [PAYLOAD_LEN_W-1:0] r_length;
    logic [1:0]               r_status;

    assign o_pop = i_valid && (!r_tvalid || i_tready);

    // Payload counter, saturating
    always_comb begin
        n_count = r_count;
        if (o_pop) begin
            if (i_cmd.clr) begin
                n_count = '0;
            end else if (i_cmd.emit && (r_count != CountMax)) begin
                n_count = r_count + LENGTH_BITS'(1);
            end
        end
    end

    // Reported length, XMP padding removed
    always_comb begin
        w_len = r_count;
        if ((i_cmd.kind == KIND_XMP) && (r_count > Padding)) begin
            w_len = r_count - Padding;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_tvalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (o_pop) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pvalid <= i_cmd.emit;
            r_kind   <= i_cmd.kind;
            r_data   <= i_cmd.data;
            r_end    <= i_cmd.fin;
            r_length <= i_cmd.fin ? PAYLOAD_LEN_W'(w_len) : '0;
            r_status <= i_cmd.status;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_pvalid = r_pvalid;
    assign o_kind   = r_kind;
    assign o_data   = r_data;
    assign o_end    = r_end;
    assign o_length = r_length;
    assign o_status = r_status;

endmodule
